// ----- hdl/f2e4m3_pkg.sv -----
// Shared types, register indexes and rounding helper for the FP32 to FP8 E4M3 converter.
// No dependencies; imported by fp32_to_fp8_e4m3_convert.
package f2e4m3_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROUND_MODE      = 3'd0;
  localparam logic [2:0] CFG_KEEP_SUBNORMALS = 3'd1;
  localparam logic [2:0] CFG_CLAMP_OVERFLOW  = 3'd2;
  localparam logic [2:0] CFG_TINY_BEFORE_RND = 3'd3;

  // Rounding modes.
  localparam logic [1:0] RM_NEAREST_EVEN = 2'd0;
  localparam logic [1:0] RM_TOWARD_MINUS = 2'd1;
  localparam logic [1:0] RM_TOWARD_PLUS  = 2'd2;
  localparam logic [1:0] RM_TOWARD_ZERO  = 2'd3;

  // Magnitudes of the NaN code and of the largest finite value (448).
  localparam logic [6:0] NAN_MAG = 7'h7F;
  localparam logic [6:0] MAX_MAG = 7'h7E;

  // Single-precision exponent codes at the edges of the E4M3 ranges.
  localparam logic [7:0] EXP_ALL_ONES   = 8'hFF;
  localparam logic [7:0] EXP_MIN_NORMAL = 8'd121;  // 2^-6
  localparam logic [7:0] EXP_ALIGN_MIN  = 8'd98;   // below this only sticky survives

  typedef enum logic [2:0] {
    CLS_ZERO,    // signed zero, no flags
    CLS_NAN,     // infinity or NaN in, signed NaN out
    CLS_FLUSH,   // tiny result flushed to signed zero
    CLS_NORMAL,  // normal-range rounding
    CLS_SUBNORM  // subnormal-precision rounding
  } cls_e;

  typedef struct packed {
    logic       sign;
    cls_e       cls;
    logic       inv;
    logic       ovf_pre;  // biased exponent already above 15
    logic [3:0] be;       // biased E4M3 exponent, low bits
    logic [3:0] mant;     // hidden bit and three kept bits
    logic       rnd;
    logic       stk;
  } s2_t;

  function automatic logic round_inc(input logic [1:0] mode, input logic sign,
                                     input logic lsb, input logic rnd, input logic stk);
    logic inc;
    inc = 1'b0;
    case (mode)
      RM_NEAREST_EVEN: inc = rnd & (lsb | stk);
      RM_TOWARD_MINUS: inc = sign & (rnd | stk);
      RM_TOWARD_PLUS:  inc = ~sign & (rnd | stk);
      default:         inc = 1'b0;
    endcase
    return inc;
  endfunction

endpackage

// ----- hdl/fp32_to_fp8_e4m3_convert.sv -----
// FP32 to FP8 E4M3 converter: three-stage pipeline with valid/stall channels.
// Depends on f2e4m3_pkg (types, register indexes, rounding helper).
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   single_bits_i[31:0]
//   out      source     out_valid_o / out_stall_i fp8_byte_o[7:0], four flags
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i[2:0], cfg_data_i[1:0]
//
// An accepted transaction passes through the three register stages in order: input
// capture, classify and align, round and pack, the last of which drives the output.
// One transaction is accepted per cycle in steady state while out_stall_i is low.
// Reset clears the stage valid bits and loads the configuration defaults.
// A stall on the output holds the output register; each stage moves only when
// the next one is empty or moving, so transactions are neither lost nor repeated.
module fp32_to_fp8_e4m3_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] single_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fp8_byte_o,
  output logic        inexact_flag_o,
  output logic        underflow_flag_o,
  output logic        overflow_flag_o,
  output logic        invalid_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i
);
  import f2e4m3_pkg::*;

  // Configuration registers. The user must change them only while the pipeline is empty
  // (the block itself does not enforce this), so every stage reads them directly.
  logic [1:0] round_mode_q;
  logic       keep_sub_q;
  logic       clamp_q;
  logic       tiny_before_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_mode_q  <= RM_NEAREST_EVEN;
      keep_sub_q    <= 1'b1;
      clamp_q       <= 1'b0;
      tiny_before_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROUND_MODE:      round_mode_q  <= cfg_data_i;
        CFG_KEEP_SUBNORMALS: keep_sub_q    <= cfg_data_i[0];
        CFG_CLAMP_OVERFLOW:  clamp_q       <= cfg_data_i[0];
        CFG_TINY_BEFORE_RND: tiny_before_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. A stage advances when the stage after it is empty
  // or is itself advancing in this cycle.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage 1: capture the input word.
  logic [31:0] x_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      x_q <= single_bits_i;
    end
  end

  // Stage 2: classify the input and align the significand. Normal-range values keep
  // the top four significand bits; values below 2^-6 are flushed or, if subnormals are
  // kept, shifted to subnormal precision, every bit shifted out folded into sticky.
  logic        x_sign;
  logic [7:0]  x_exp;
  logic [22:0] x_frac;
  logic [23:0] sig;
  logic [7:0]  shamt;
  logic [47:0] shifted;
  logic [7:0]  be_full;
  s2_t         s2_d, s2_q;

  assign x_sign  = x_q[31];
  assign x_exp   = x_q[30:23];
  assign x_frac  = x_q[22:0];
  assign sig     = {(x_exp != 8'd0), x_frac};
  assign shamt   = EXP_MIN_NORMAL - x_exp;
  assign shifted = {sig, 24'd0} >> shamt[4:0];
  assign be_full = x_exp - 8'd120;

  always_comb begin
    s2_d         = '0;
    s2_d.sign    = x_sign;
    s2_d.cls     = CLS_ZERO;
    s2_d.ovf_pre = (be_full > 8'd15);
    s2_d.be      = be_full[3:0];
    if (x_exp == 8'd0 && (x_frac == 23'd0 || !keep_sub_q)) begin
      s2_d.cls = CLS_ZERO;
    end else if (x_exp == EXP_ALL_ONES) begin
      s2_d.cls = CLS_NAN;
      // A NaN with the quiet bit clear is signalling.
      s2_d.inv = (x_frac != 23'd0) && !x_frac[22];
    end else if (x_exp >= EXP_MIN_NORMAL) begin
      s2_d.cls  = CLS_NORMAL;
      s2_d.mant = sig[23:20];
      s2_d.rnd  = sig[19];
      s2_d.stk  = |sig[18:0];
    end else if (!keep_sub_q) begin
      s2_d.cls = CLS_FLUSH;
    end else begin
      s2_d.cls = CLS_SUBNORM;
      if (x_exp == 8'd0 || x_exp < EXP_ALIGN_MIN) begin
        // Shifted past every kept and round position: only sticky remains.
        s2_d.stk = 1'b1;
      end else begin
        s2_d.mant = shifted[47:44];
        s2_d.rnd  = shifted[43];
        s2_d.stk  = |shifted[42:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: round, detect overflow and tininess, and pack the result byte.
  logic       inc;
  logic [4:0] m5;
  logic [2:0] n_mant;
  logic [4:0] n_be;
  logic       n_ovf;
  logic       sub_tiny;
  logic [7:0] byte_d;
  logic       inx_d, unf_d, ovf_d, inv_d;

  assign inc      = round_inc(round_mode_q, s2_q.sign, s2_q.mant[0], s2_q.rnd, s2_q.stk);
  assign m5       = {1'b0, s2_q.mant} + {4'd0, inc};
  assign n_mant   = m5[4] ? m5[3:1] : m5[2:0];
  assign n_be     = {1'b0, s2_q.be} + {4'd0, m5[4]};
  assign n_ovf    = s2_q.ovf_pre || (n_be > 5'd15) || (n_be == 5'd15 && n_mant == 3'd7);
  assign sub_tiny = tiny_before_q || !m5[3];

  always_comb begin
    byte_d = {s2_q.sign, 7'd0};
    inx_d  = 1'b0;
    unf_d  = 1'b0;
    ovf_d  = 1'b0;
    inv_d  = 1'b0;
    case (s2_q.cls)
      CLS_NAN: begin
        byte_d = {s2_q.sign, NAN_MAG};
        inv_d  = s2_q.inv;
      end
      CLS_FLUSH: begin
        unf_d = 1'b1;
        inx_d = 1'b1;
      end
      CLS_NORMAL: begin
        inx_d = s2_q.rnd | s2_q.stk | n_ovf;
        ovf_d = n_ovf;
        if (n_ovf) begin
          // Without clamping, overflow goes to NaN or to 448 by rounding direction.
          if (clamp_q || round_mode_q == RM_TOWARD_ZERO) begin
            byte_d = {s2_q.sign, MAX_MAG};
          end else if (round_mode_q == RM_NEAREST_EVEN) begin
            byte_d = {s2_q.sign, NAN_MAG};
          end else if (round_mode_q == RM_TOWARD_PLUS) begin
            byte_d = {s2_q.sign, s2_q.sign ? MAX_MAG : NAN_MAG};
          end else begin
            byte_d = {s2_q.sign, s2_q.sign ? NAN_MAG : MAX_MAG};
          end
        end else begin
          byte_d = {s2_q.sign, n_be[3:0], n_mant};
        end
      end
      CLS_SUBNORM: begin
        // A carry into bit 3 lands on the smallest normal, exponent field 1.
        inx_d  = s2_q.rnd | s2_q.stk;
        unf_d  = (s2_q.rnd | s2_q.stk) & sub_tiny;
        byte_d = {s2_q.sign, 3'd0, m5[3], m5[2:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      fp8_byte_o       <= byte_d;
      inexact_flag_o   <= inx_d;
      underflow_flag_o <= unf_d;
      overflow_flag_o  <= ovf_d;
      invalid_flag_o   <= inv_d;
    end
  end

  assign out_valid_o = v3_q;

  // Overflow and underflow are always reported together with inexact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (overflow_flag_o || underflow_flag_o) |-> inexact_flag_o)
    else $error("overflow or underflow without inexact");

  // An invalid operation only comes from a NaN input and always yields NaN.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_flag_o |-> fp8_byte_o[6:0] == NAN_MAG && !inexact_flag_o)
    else $error("invalid flag on a non-NaN result");

  // A full middle stage blocked by the output register keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !adv3 |=> v2_q && $stable(s2_q))
    else $error("middle stage changed while blocked");

  // An accepted transaction always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted transaction lost at stage one");

endmodule
